### hdl/mie_pkg.sv
// shared types for the modular inverse unit
package mie_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALIGN,
        ST_SUB,
        ST_STEP,
        ST_FIN
    } t_state;

    localparam logic [63:0] MODULUS_RESET = 64'd4294967291;

endpackage

### hdl/mie_if.sv
// stream and configuration interfaces of the modular inverse unit
interface mie_in_if #(
    parameter int DATA_WIDTH = 32
);
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface mie_out_if #(
    parameter int DATA_WIDTH = 32
);
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] inverse;
    logic                  status;

    modport source (output valid, output inverse, output status, input ready);
    modport sink   (input valid, input inverse, input status, output ready);
endinterface

interface mie_cfg_if #(
    parameter int DATA_WIDTH = 32
);
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] modulus;

    modport source (output valid, output modulus, input ready);
    modport sink   (input valid, input modulus, output ready);
endinterface

### hdl/modular_inverse_euclid_unit.sv
// modular inverse by the extended euclidean algorithm, shift-subtract sequencer
//
//  channel  dir  payload             notes
//  i_in     in   value               taken only while idle
//  o_out    out  inverse, status     held in output register until transfer
//  i_cfg    in   modulus             always ready, reset value 4294967291
//
// each euclid step aligns the divisor, one quotient bit per cycle,
// shifts it back while subtracting and then advances through ST_STEP
// the shift-subtract unit on remainder and coefficient sets the running time
// a new item is taken once the result is in the output register
// synchronous active-low reset clears the sequencer and output valid and loads the reset modulus
module modular_inverse_euclid_unit
    import mie_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mie_in_if.sink    i_in,
    mie_out_if.source o_out,
    mie_cfg_if.sink   i_cfg
);

    localparam int TW = DATA_WIDTH + 2;
    localparam int KW = $clog2(DATA_WIDTH);

    t_state                  r_state, n_state;
    logic [DATA_WIDTH-1:0]   r_modulus;
    logic [DATA_WIDTH-1:0]   r_rem, n_rem;
    logic [DATA_WIDTH:0]     r_d, n_d;
    logic signed [TW-1:0]    r_tacc, n_tacc;
    logic signed [TW-1:0]    r_td, n_td;
    logic [DATA_WIDTH-1:0]   r_r1, n_r1;
    logic signed [TW-1:0]    r_t1, n_t1;
    logic [KW-1:0]           r_k, n_k;
    logic                    r_reduce, n_reduce;
    logic                    r_fail, n_fail;
    logic                    r_out_valid, n_out_valid;
    logic [DATA_WIDTH-1:0]   r_out_inverse, n_out_inverse;
    logic                    r_out_status, n_out_status;

    logic                    w_fits;
    logic                    w_sub_ok;
    logic signed [TW-1:0]    w_fixed;

    assign i_in.ready    = (r_state == ST_IDLE);
    assign i_cfg.ready   = 1'b1;
    assign o_out.valid   = r_out_valid;
    assign o_out.inverse = r_out_inverse;
    assign o_out.status  = r_out_status;

    assign w_fits   = {r_d, 1'b0} <= {2'b00, r_rem};
    assign w_sub_ok = r_d <= {1'b0, r_rem};
    assign w_fixed  = r_t1[TW-1] ? (r_t1 + TW'(r_modulus)) : r_t1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_modulus   <= MODULUS_RESET[DATA_WIDTH-1:0];
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_modulus <= i_cfg.modulus;
            end
        end
        r_rem         <= n_rem;
        r_d           <= n_d;
        r_tacc        <= n_tacc;
        r_td          <= n_td;
        r_r1          <= n_r1;
        r_t1          <= n_t1;
        r_k           <= n_k;
        r_reduce      <= n_reduce;
        r_fail        <= n_fail;
        r_out_inverse <= n_out_inverse;
        r_out_status  <= n_out_status;
    end

    always_comb begin
        n_state       = r_state;
        n_rem         = r_rem;
        n_d           = r_d;
        n_tacc        = r_tacc;
        n_td          = r_td;
        n_r1          = r_r1;
        n_t1          = r_t1;
        n_k           = r_k;
        n_reduce      = r_reduce;
        n_fail        = r_fail;
        n_out_valid   = r_out_valid;
        n_out_inverse = r_out_inverse;
        n_out_status  = r_out_status;

        if (o_out.valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_rem    = i_in.value;
                    n_d      = {1'b0, r_modulus};
                    n_k      = '0;
                    n_tacc   = '0;
                    n_td     = '0;
                    n_reduce = 1'b1;
                    n_fail   = 1'b0;
                    if (r_modulus < DATA_WIDTH'(2)) begin
                        n_fail  = 1'b1;
                        n_state = ST_FIN;
                    end else begin
                        n_state = ST_ALIGN;
                    end
                end
            end
            ST_ALIGN: begin
                if (w_fits) begin
                    n_d  = {r_d[DATA_WIDTH-1:0], 1'b0};
                    n_td = r_td <<< 1;
                    n_k  = r_k + KW'(1);
                end else begin
                    n_state = ST_SUB;
                end
            end
            ST_SUB: begin
                if (w_sub_ok) begin
                    n_rem  = r_rem - r_d[DATA_WIDTH-1:0];
                    n_tacc = r_tacc - r_td;
                end
                if (r_k == '0) begin
                    n_state = ST_STEP;
                end else begin
                    n_d  = r_d >> 1;
                    n_td = r_td >>> 1;
                    n_k  = r_k - KW'(1);
                end
            end
            ST_STEP: begin
                n_k      = '0;
                n_reduce = 1'b0;
                n_r1     = r_rem;
                n_d      = {1'b0, r_rem};
                if (r_reduce) begin
                    n_rem  = r_modulus;
                    n_tacc = '0;
                    n_td   = TW'(1);
                    n_t1   = TW'(1);
                    if (r_rem == '0) begin
                        n_fail  = 1'b1;
                        n_state = ST_FIN;
                    end else begin
                        n_state = ST_ALIGN;
                    end
                end else if (r_rem == '0) begin
                    n_r1    = r_r1;
                    n_fail  = (r_r1 != DATA_WIDTH'(1));
                    n_state = ST_FIN;
                end else begin
                    n_rem   = r_r1;
                    n_tacc  = r_t1;
                    n_td    = r_tacc;
                    n_t1    = r_tacc;
                    n_state = ST_ALIGN;
                end
            end
            ST_FIN: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid   = 1'b1;
                    n_out_status  = r_fail;
                    n_out_inverse = r_fail ? '0 : w_fixed[DATA_WIDTH-1:0];
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ALIGN || r_state == ST_SUB) |-> (r_d != '0))
        else $error("divisor is zero during division");

    a_remainder_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STEP) |-> ({1'b0, r_rem} < r_d))
        else $error("remainder not below divisor after division");

    a_sub_ends_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SUB && r_k == '0) |=> (r_state == ST_STEP))
        else $error("division did not finish on last quotient bit");

    a_inverse_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_status) |-> (r_out_inverse < r_modulus))
        else $error("inverse not below modulus");

    a_fail_gives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status) |-> (r_out_inverse == '0))
        else $error("no-inverse result carries nonzero value");
`endif

endmodule

### tb/sv/modular_inverse_euclid_unit_tb.sv
// self-checking testbench for the extended euclid modular inverse unit
`timescale 1ns / 1ps

module modular_inverse_euclid_unit_tb
    import mie_pkg::*;
();

    localparam int DW           = 32;
    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_ITEMS = 1150;
    localparam int PHASES       = 8;
    localparam int HOLD_CYCLES  = 3000;
    localparam int DRAIN_CYCLES = 400;
    localparam int IDLE_LIMIT   = 20000;

    localparam logic INV_FOUND = 1'b0;
    localparam logic INV_NONE  = 1'b1;

    typedef enum int {
        PACE_FULL,
        PACE_SRC_IDLE,
        PACE_SNK_STALL,
        PACE_BOTH
    } t_pace;

    typedef enum int {
        MOD_RESET_PRIME,
        MOD_LARGE,
        MOD_MAX,
        MOD_16BIT,
        MOD_FIBONACCI,
        MOD_ODD,
        MOD_POW2,
        MOD_TINY
    } t_mod_kind;

    typedef struct packed {
        logic [DW-1:0] inverse;
        logic          status;
    } t_inv_result;

    typedef struct packed {
        logic [DW-1:0] modulus;
        logic [DW-1:0] value;
        logic          typed;
        logic [DW-1:0] inverse;
        logic          status;
    } t_stim_row;

    localparam int N_DIRECTED = 22;
    localparam t_stim_row DIRECTED [0:N_DIRECTED-1] = '{
        '{32'd4294967291, 32'd0,          1'b1, 32'd0,          INV_NONE},
        '{32'd4294967291, 32'd1,          1'b1, 32'd1,          INV_FOUND},
        '{32'd4294967291, 32'd2,          1'b1, 32'd2147483646, INV_FOUND},
        '{32'd4294967291, 32'd4294967290, 1'b1, 32'd4294967290, INV_FOUND},
        '{32'd4294967291, 32'd4294967291, 1'b1, 32'd0,          INV_NONE},
        '{32'd4294967291, 32'd4294967295, 1'b0, 32'd0,          INV_FOUND},
        '{32'd4294967291, 32'h5555aaaa,   1'b0, 32'd0,          INV_FOUND},
        '{32'd2,          32'd0,          1'b1, 32'd0,          INV_NONE},
        '{32'd2,          32'd1,          1'b1, 32'd1,          INV_FOUND},
        '{32'd2,          32'd2,          1'b1, 32'd0,          INV_NONE},
        '{32'd2,          32'd4294967295, 1'b1, 32'd1,          INV_FOUND},
        '{32'd4294967295, 32'd2,          1'b1, 32'd2147483648, INV_FOUND},
        '{32'd4294967295, 32'd3,          1'b1, 32'd0,          INV_NONE},
        '{32'd4294967295, 32'd4294967294, 1'b1, 32'd4294967294, INV_FOUND},
        '{32'd4294967295, 32'd4294967295, 1'b1, 32'd0,          INV_NONE},
        '{32'd4294967295, 32'd65537,      1'b1, 32'd0,          INV_NONE},
        '{32'd4294967295, 32'd1,          1'b1, 32'd1,          INV_FOUND},
        '{32'd2971215073, 32'd1836311903, 1'b0, 32'd0,          INV_FOUND},
        '{32'd2971215073, 32'd1134903170, 1'b0, 32'd0,          INV_FOUND},
        '{32'd65536,      32'd65535,      1'b1, 32'd65535,      INV_FOUND},
        '{32'd65536,      32'd32768,      1'b1, 32'd0,          INV_NONE},
        '{32'd65536,      32'd3,          1'b0, 32'd0,          INV_FOUND}
    };

    logic clk;
    logic rst_n;

    mie_in_if  #(.DATA_WIDTH(DW)) in_ch ();
    mie_out_if #(.DATA_WIDTH(DW)) out_ch ();
    mie_cfg_if #(.DATA_WIDTH(DW)) cfg_ch ();

    modular_inverse_euclid_unit #(
        .DATA_WIDTH(DW)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    t_inv_result   expected_inverses[$];
    logic [DW-1:0] cur_modulus = MODULUS_RESET[DW-1:0];
    int            fail_count = 0;
    int            src_idle_pct = 0;
    int            snk_stall_pct = 0;
    int            hold_request = 0;
    int            quiet_cycles = 0;

    function automatic t_inv_result inverse_mod(input logic [DW-1:0] v, input logic [DW-1:0] m);
        t_inv_result res;
        logic [63:0] r_prev, r_cur, quot, r_next;
        longint      c_prev, c_cur, c_next;
        res.inverse = '0;
        res.status  = INV_NONE;
        if (m < 2) return res;
        r_prev = 64'(m);
        r_cur  = 64'(v) % 64'(m);
        if (r_cur == 0) return res;
        c_prev = 0;
        c_cur  = 1;
        while (r_cur != 0) begin
            quot   = r_prev / r_cur;
            r_next = r_prev - quot * r_cur;
            c_next = c_prev - longint'(quot) * c_cur;
            r_prev = r_cur;
            r_cur  = r_next;
            c_prev = c_cur;
            c_cur  = c_next;
        end
        if (r_prev != 1) return res;
        if (c_prev < 0) c_prev = c_prev + longint'(m);
        res.inverse = c_prev[DW-1:0];
        res.status  = INV_FOUND;
        return res;
    endfunction

    function automatic logic [DW-1:0] pick_modulus(input t_mod_kind kind);
        logic [DW-1:0] m;
        case (kind)
            MOD_RESET_PRIME: m = MODULUS_RESET[DW-1:0];
            MOD_LARGE:       m = $urandom | 32'h8000_0000;
            MOD_MAX:         m = '1;
            MOD_16BIT:       m = $urandom_range(65535, 2);
            MOD_FIBONACCI:   m = 32'd2971215073;
            MOD_ODD:         m = $urandom | 32'h0000_0003;
            MOD_POW2:        m = 32'd1 << $urandom_range(31, 1);
            default:         m = $urandom_range(255, 2);
        endcase
        return m;
    endfunction

    function automatic logic [DW-1:0] pick_value(input logic [DW-1:0] m);
        int            roll;
        logic [DW-1:0] g;
        roll = $urandom_range(99);
        if (roll < 60) return $urandom;
        if (roll < 70) return $urandom_range(m - 1, 0);
        if (roll < 76) return m * $urandom_range(32'hffff_ffff / m, 0);
        if (roll < 82) begin
            case ($urandom_range(3))
                0: return m - 1;
                1: return m + 1;
                2: return 1;
                default: return '1;
            endcase
        end
        if (roll < 90) return $urandom_range(255, 0);
        case ($urandom_range(4))
            0: g = 2;
            1: g = 3;
            2: g = 5;
            3: g = 17;
            default: g = 257;
        endcase
        return g * $urandom_range(32'hffff_ffff / g, 1);
    endfunction

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // sender side, entered and left at a falling edge
    task automatic send_value(input logic [DW-1:0] v, input logic typed,
                              input t_inv_result typed_res);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            in_ch.value <= $urandom;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= v;
        do @(posedge clk); while (!in_ch.ready);
        if (typed) expected_inverses.push_back(typed_res);
        else expected_inverses.push_back(inverse_mod(v, cur_modulus));
        @(negedge clk);
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        while (expected_inverses.size() != 0) @(negedge clk);
        @(negedge clk);
    endtask

    task automatic write_modulus(input logic [DW-1:0] m);
        cfg_ch.valid   <= 1'b1;
        cfg_ch.modulus <= m;
        do @(posedge clk); while (!cfg_ch.ready);
        cur_modulus = m;
        @(negedge clk);
        cfg_ch.valid   <= 1'b0;
        cfg_ch.modulus <= $urandom;
    endtask

    task automatic set_pace(input t_pace pace);
        case (pace)
            PACE_FULL:      begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            PACE_SRC_IDLE:  begin src_idle_pct = 84; snk_stall_pct = 0;  end
            PACE_SNK_STALL: begin src_idle_pct = 0;  snk_stall_pct = 84; end
            default:        begin src_idle_pct = 12; snk_stall_pct = 12; end
        endcase
    endtask

    // receiver side
    initial begin
        int hold;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request > 0) begin
                hold = hold_request;
                hold_request = 0;
                out_ch.ready <= 1'b0;
                repeat (hold) @(negedge clk);
            end else begin
                out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    always @(posedge clk) begin
        t_inv_result want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_inverses.size() == 0) begin
                $error("unexpected result transfer: inverse %0d status %0d",
                       out_ch.inverse, out_ch.status);
                fail_count++;
            end else begin
                want = expected_inverses.pop_front();
                if (out_ch.inverse !== want.inverse) begin
                    $error("inverse mismatch: expected %0d, actual %0d",
                           want.inverse, out_ch.inverse);
                    fail_count++;
                end
                if (out_ch.status !== want.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want.status, out_ch.status);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_stim_row row;
        int        per_phase;
        t_pace     pace;
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.value    = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.modulus = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_pace(PACE_FULL);
        for (int i = 0; i < N_DIRECTED; i++) begin
            row = DIRECTED[i];
            if (row.modulus != cur_modulus) begin
                settle();
                write_modulus(row.modulus);
            end
            send_value(row.value, row.typed, '{inverse: row.inverse, status: row.status});
        end

        per_phase = RANDOM_ITEMS / PHASES;
        for (int p = 0; p < PHASES; p++) begin
            settle();
            pace = t_pace'(p % 4);
            set_pace(pace);
            write_modulus(pick_modulus(t_mod_kind'(p)));
            // long receiver hold-off while items keep coming
            if (p == 0) hold_request = HOLD_CYCLES;
            for (int n = 0; n < per_phase; n++) begin
                send_value(pick_value(cur_modulus), 1'b0, '0);
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && expected_inverses.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/mie_pkg.sv
hdl/mie_if.sv
hdl/modular_inverse_euclid_unit.sv
tb/sv/modular_inverse_euclid_unit_tb.sv
